// ----- src/biu_pkg.sv -----
// ----------------------------------------------------------------------------
// biu_pkg
// shared constants, reciprocal table and control types for the upscaler
// ----------------------------------------------------------------------------
`default_nettype none

package biu_pkg;

  localparam int CW  = 11;  // coordinate width
  localparam int SW  = 5;   // effective scale width, 1..15
  localparam int PW  = 24;  // packed pixel width
  localparam int KSH = 21;  // reciprocal fraction bits
  localparam int RW  = 22;  // reciprocal width

  // ceil(2^21 / s), index 0 unused
  localparam logic [RW-1:0] RECIP [0:16] = '{
    22'd0,      22'd2097152, 22'd1048576, 22'd699051,
    22'd524288, 22'd419431,  22'd349526,  22'd299594,
    22'd262144, 22'd233017,  22'd209716,  22'd190651,
    22'd174763, 22'd161320,  22'd149797,  22'd139811,
    22'd131072
  };

  typedef struct packed {
    logic valid;
    logic err;
  } ctl_t;

endpackage

`default_nettype wire

// ----- src/bilinear_integer_upscaler_core.sv -----
// ----------------------------------------------------------------------------
// bilinear_integer_upscaler_core
// source frame store and bilinear read-out of the frame upscaled by an
// integer factor
// ----------------------------------------------------------------------------
//  channel  ports   tdata (low bit up)                  tuser
//  input    in_     row, col, red, green, blue          mode
//  output   out_    red, green, blue                    range_error
//  config   cfg_    scale_factor                        -
//
//  one beat per cycle in unless out_tready stalls, one result beat per read,
//  through coordinate divide, bank read, weights, sums, two reciprocal divides
//  the frame lives in four row/column parity banks so all four neighbors
//  come out of one registered read
//  a stall on out_tready freezes every stage; in_tready follows it
//  reset clears valid bits and sets the scale to 1; frame content is kept
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_integer_upscaler_core #(
  parameter int SRC_SIZE  = 256,
  parameter int MAX_SCALE = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [3:0]  cfg_wr_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // row, col, red, green, blue
  input  wire logic        in_tuser,   // mode
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // red, green, blue
  output logic             out_tuser   // range_error
);

  localparam int CW   = biu_pkg::CW;
  localparam int SW   = biu_pkg::SW;
  localparam int PW   = biu_pkg::PW;
  localparam int HALF = (SRC_SIZE + 1) / 2;
  localparam int DEP  = HALF * HALF;
  localparam int AW   = (DEP > 1) ? $clog2(DEP) : 1;

  logic                adv;
  logic [3:0]          scale_r;
  logic [SW-1:0]       s;

  logic                v1_r, mode1_r;
  logic [CW-1:0]       row1_r, col1_r;
  logic [PW-1:0]       pix1_r;

  logic [CW+biu_pkg::RW-1:0] prow, pcol;
  logic [15:0]         lim;
  logic                err1;

  logic                v2_r, mode2_r, err2_r;
  logic [CW-1:0]       row2_r, col2_r, qr2_r, qc2_r;
  logic [PW-1:0]       pix2_r;

  logic [CW-1:0]       frw, fcw, r1, c1;
  logic [CW-1:0]       rsel [2];
  logic [CW-1:0]       csel [2];
  logic                wr_ok;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr [4];
  logic [PW-1:0]       rd    [4];

  biu_pkg::ctl_t       ctl3_r;
  logic [SW-1:0]       fr3_r, fc3_r;
  logic                r0p_r, r1p_r, c0p_r, c1p_r;
  logic [3:0][PW-1:0]  nb;
  biu_pkg::ctl_t       ctl_o;
  logic [PW-1:0]       rgb;

  function automatic logic [AW-1:0] bank_addr(input logic [CW-1:0] r,
                                               input logic [CW-1:0] c);
    logic [2*CW:0] a;
    a = (2*CW+1)'(r >> 1) * (2*CW+1)'(HALF) + (2*CW+1)'(c >> 1);
    return a[AW-1:0];
  endfunction

  assign adv       = !ctl_o.valid || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= 4'd1;
    end else if (cfg_wr_en) begin
      scale_r <= cfg_wr_data;
    end
  end

  always_comb begin
    if (scale_r == 4'd0) begin
      s = SW'(1);
    end else if ({1'b0, scale_r} > SW'(MAX_SCALE)) begin
      s = SW'(MAX_SCALE);
    end else begin
      s = {1'b0, scale_r};
    end
  end

  // stage 1: input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode1_r <= in_tuser;
      row1_r  <= in_tdata[10:0];
      col1_r  <= in_tdata[21:11];
      pix1_r  <= {in_tdata[29:22], in_tdata[37:30], in_tdata[45:38]};
    end
  end

  // stage 2: coordinate divide and range check
  assign prow = {{biu_pkg::RW{1'b0}}, row1_r} * {{CW{1'b0}}, biu_pkg::RECIP[s]};
  assign pcol = {{biu_pkg::RW{1'b0}}, col1_r} * {{CW{1'b0}}, biu_pkg::RECIP[s]};
  assign lim  = 16'(SRC_SIZE) * {11'b0, s};
  assign err1 = ({5'b0, row1_r} >= lim) || ({5'b0, col1_r} >= lim);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mode2_r <= mode1_r;
      row2_r  <= row1_r;
      col2_r  <= col1_r;
      pix2_r  <= pix1_r;
      qr2_r   <= prow[biu_pkg::KSH +: CW];
      qc2_r   <= pcol[biu_pkg::KSH +: CW];
      err2_r  <= err1;
    end
  end

  // stage 3: fractions, edge clamp, bank access
  assign frw = row2_r - CW'({6'b0, qr2_r[SW-1:0]} * {6'b0, s} + 11'b0 +
                            CW'({qr2_r[CW-1:SW], {SW{1'b0}}} * {6'b0, s}));
  assign fcw = col2_r - CW'({6'b0, qc2_r[SW-1:0]} * {6'b0, s} + 11'b0 +
                            CW'({qc2_r[CW-1:SW], {SW{1'b0}}} * {6'b0, s}));
  assign r1  = ({1'b0, qr2_r} + 12'd1 < 12'(SRC_SIZE)) ? qr2_r + CW'(1) : CW'(SRC_SIZE - 1);
  assign c1  = ({1'b0, qc2_r} + 12'd1 < 12'(SRC_SIZE)) ? qc2_r + CW'(1) : CW'(SRC_SIZE - 1);

  assign wr_ok = v2_r && !mode2_r && (row2_r < CW'(SRC_SIZE)) && (col2_r < CW'(SRC_SIZE));
  assign waddr = bank_addr(row2_r, col2_r);

  for (genvar p = 0; p < 2; p++) begin : g_sel
    assign rsel[p] = (qr2_r[0] == 1'(p)) ? qr2_r : r1;
    assign csel[p] = (qc2_r[0] == 1'(p)) ? qc2_r : c1;
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    assign raddr[b] = bank_addr(rsel[b / 2], csel[b % 2]);
    biu_bank #(.DEPTH(DEP), .AW(AW)) u_bank (
      .clk   (clk),
      .we    (adv && wr_ok && ({row2_r[0], col2_r[0]} == 2'(b))),
      .waddr (waddr),
      .wdata (pix2_r),
      .re    (adv),
      .raddr (raddr[b]),
      .rdata (rd[b])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl3_r <= '0;
    end else if (adv) begin
      ctl3_r.valid <= v2_r && mode2_r;
      ctl3_r.err   <= err2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fr3_r <= frw[SW-1:0];
      fc3_r <= fcw[SW-1:0];
      r0p_r <= qr2_r[0];
      r1p_r <= r1[0];
      c0p_r <= qc2_r[0];
      c1p_r <= c1[0];
    end
  end

  // neighbors in order r0c0, r1c0, r0c1, r1c1
  assign nb[0] = rd[{r0p_r, c0p_r}];
  assign nb[1] = rd[{r1p_r, c0p_r}];
  assign nb[2] = rd[{r0p_r, c1p_r}];
  assign nb[3] = rd[{r1p_r, c1p_r}];

  biu_blend u_blend (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .s       (s),
    .fr      (fr3_r),
    .fc      (fc3_r),
    .nb      (nb),
    .ctl_in  (ctl3_r),
    .ctl_out (ctl_o),
    .rgb     (rgb)
  );

  assign out_tvalid = ctl_o.valid;
  assign out_tdata  = rgb;
  assign out_tuser  = ctl_o.err;

endmodule

`default_nettype wire

// ----- src/biu_bank.sv -----
// ----------------------------------------------------------------------------
// biu_bank
// one pixel bank, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module biu_bank #(
  parameter int DEPTH = 16384,
  parameter int AW    = 14
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [biu_pkg::PW-1:0]    wdata,
  input  wire logic                      re,
  input  wire logic [AW-1:0]             raddr,
  output logic      [biu_pkg::PW-1:0]    rdata
);

  logic [biu_pkg::PW-1:0] mem [DEPTH];
  logic [biu_pkg::PW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- src/biu_sdiv.sv -----
// ----------------------------------------------------------------------------
// biu_sdiv
// two-stage divide of a 16-bit value by the scale via reciprocal multiply
// ----------------------------------------------------------------------------
`default_nettype none

module biu_sdiv (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [biu_pkg::SW-1:0] s,
  input  wire logic [15:0]            n,
  output logic      [15:0]            q
);

  logic [biu_pkg::RW-1:0]   rec;
  logic [biu_pkg::RW+7:0]   plo_r;
  logic [biu_pkg::RW+7:0]   phi_r;
  logic [biu_pkg::RW+15:0]  tot;
  logic [15:0]              q_r;

  assign rec = biu_pkg::RECIP[s];
  assign tot = {phi_r, 8'b0} + (biu_pkg::RW+16)'(plo_r);

  always_ff @(posedge clk) begin
    if (en) begin
      plo_r <= {{biu_pkg::RW{1'b0}}, n[7:0]}  * {8'b0, rec};
      phi_r <= {{biu_pkg::RW{1'b0}}, n[15:8]} * {8'b0, rec};
      q_r   <= tot[biu_pkg::KSH +: 16];
    end
  end

  assign q = q_r;

endmodule

`default_nettype wire

// ----- src/biu_blend.sv -----
// ----------------------------------------------------------------------------
// biu_blend
// weights, weighted sums and division by scale squared, six stages
// ----------------------------------------------------------------------------
`default_nettype none

module biu_blend (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           adv,
  input  wire logic [biu_pkg::SW-1:0]         s,
  input  wire logic [biu_pkg::SW-1:0]         fr,
  input  wire logic [biu_pkg::SW-1:0]         fc,
  input  wire logic [3:0][biu_pkg::PW-1:0]    nb,
  input  wire biu_pkg::ctl_t                  ctl_in,
  output biu_pkg::ctl_t                       ctl_out,
  output logic      [biu_pkg::PW-1:0]         rgb
);

  localparam int NST = 6;

  biu_pkg::ctl_t               ctl_r [NST];
  logic [8:0]                  w_r   [4];
  logic [3:0][biu_pkg::PW-1:0] nb_r;
  logic [15:0]                 sum_r [3];
  logic [15:0]                 sum_nxt [3];
  logic [15:0]                 q1    [3];
  logic [15:0]                 q2    [3];
  logic [biu_pkg::SW-1:0]      sr, sc;

  assign sr = s - fr;
  assign sc = s - fc;

  always_ff @(posedge clk) begin
    if (adv) begin
      w_r[0] <= 9'({4'b0, sr} * {4'b0, sc});
      w_r[1] <= 9'({4'b0, fr} * {4'b0, sc});
      w_r[2] <= 9'({4'b0, sr} * {4'b0, fc});
      w_r[3] <= 9'({4'b0, fr} * {4'b0, fc});
      nb_r   <= nb;
      sum_r  <= sum_nxt;
    end
  end

  always_comb begin
    logic [17:0] acc;
    for (int c = 0; c < 3; c++) begin
      acc = '0;
      for (int k = 0; k < 4; k++) begin
        acc = acc + 18'({w_r[k]} * {9'b0, nb_r[k][16 - 8*c +: 8]});
      end
      sum_nxt[c] = acc[15:0];
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_ch
    biu_sdiv u_div1 (.clk(clk), .en(adv), .s(s), .n(sum_r[c]), .q(q1[c]));
    biu_sdiv u_div2 (.clk(clk), .en(adv), .s(s), .n(q1[c]),    .q(q2[c]));
    assign rgb[8*c +: 8] = ctl_r[NST-1].err ? 8'd0 : q2[c][7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NST; i++) begin
        ctl_r[i] <= '0;
      end
    end else if (adv) begin
      ctl_r[0] <= ctl_in;
      for (int i = 1; i < NST; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end
  end

  assign ctl_out = ctl_r[NST-1];

endmodule

`default_nettype wire

// ----- src/biu_check.sv -----
// ----------------------------------------------------------------------------
// biu_check
// port-level checks on the upscaler core, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module biu_check (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic        out_tuser
);

  // out-of-range reads carry a black pixel
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 24'd0)
    else $error("range error beat with nonzero color");

  // input side never blocks while output register is empty
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed under stall");

  // nothing comes out right after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("valid result after reset");

endmodule

bind bilinear_integer_upscaler_core biu_check u_biu_check (.*);

`default_nettype wire

// ----- test/bilinear_integer_upscaler_core_tb.sv -----
// ----------------------------------------------------------------------------
// bilinear_integer_upscaler_core_tb
// drives write and read beats through the upscaler over several scale
// settings and checks every result beat against an in-bench predictor of the
// bilinear blend, the edge clamp and the range error
// ----------------------------------------------------------------------------
`default_nettype none

class upscale_scoreboard;
  logic [23:0] frame [0:65535];
  bit          written [0:65535];
  logic [3:0]  scale_reg;
  logic [24:0] pending [$];   // range_error, blue, green, red
  int          errors;

  function new();
    scale_reg = 4'd1;
    errors = 0;
  endfunction

  function int eff_scale();
    if (scale_reg == 4'd0) return 1;
    if (scale_reg > 4'd8) return 8;
    return scale_reg;
  endfunction

  function bit is_written(int r, int c);
    return written[r * 256 + c];
  endfunction

  function logic [7:0] mix(int sh, int s, int fr, int fc, logic [23:0] a, logic [23:0] b,
                           logic [23:0] c, logic [23:0] d);
    int sum;
    sum = (s - fr) * (s - fc) * ((a >> sh) & 255) + fr * (s - fc) * ((b >> sh) & 255)
        + (s - fr) * fc * ((c >> sh) & 255) + fr * fc * ((d >> sh) & 255);
    return (sum / (s * s)) & 255;
  endfunction

  function void note_input(bit mode, int row, int col, logic [23:0] rgb);
    int s, r0, r1, c0, c1, fr, fc;
    logic [23:0] a, b, c, d;
    if (!mode) begin
      if (row < 256 && col < 256) begin
        frame[row * 256 + col] = rgb;
        written[row * 256 + col] = 1'b1;
      end
      return;
    end
    s = eff_scale();
    if (row >= 256 * s || col >= 256 * s) begin
      pending.push_back({1'b1, 24'd0});
      return;
    end
    r0 = row / s;
    c0 = col / s;
    fr = row % s;
    fc = col % s;
    r1 = (r0 < 255) ? r0 + 1 : 255;
    c1 = (c0 < 255) ? c0 + 1 : 255;
    a = frame[r0 * 256 + c0];
    b = frame[r1 * 256 + c0];
    c = frame[r0 * 256 + c1];
    d = frame[r1 * 256 + c1];
    pending.push_back({1'b0, mix(0, s, fr, fc, a, b, c, d), mix(8, s, fr, fc, a, b, c, d),
                       mix(16, s, fr, fc, a, b, c, d)});
  endfunction

  function void check_result(logic [23:0] data, logic err);
    logic [24:0] exp_beat;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result beat data=%h err=%b", $time, data, err);
      errors++;
      return;
    end
    exp_beat = pending.pop_front();
    if (data[7:0] !== exp_beat[7:0]) begin
      $display("%0t: red expected %h actual %h", $time, exp_beat[7:0], data[7:0]);
      errors++;
    end
    if (data[15:8] !== exp_beat[15:8]) begin
      $display("%0t: green expected %h actual %h", $time, exp_beat[15:8], data[15:8]);
      errors++;
    end
    if (data[23:16] !== exp_beat[23:16]) begin
      $display("%0t: blue expected %h actual %h", $time, exp_beat[23:16], data[23:16]);
      errors++;
    end
    if (err !== exp_beat[24]) begin
      $display("%0t: range_error expected %b actual %b", $time, exp_beat[24], err);
      errors++;
    end
  endfunction
endclass

module bilinear_integer_upscaler_core_tb;

  localparam int LIMIT = 400000;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [3:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;

  upscale_scoreboard sb;
  int  cycles;
  int  src_idle, dst_idle;
  bit  hold_req;
  int  hold_left;
  bit  done;

  bilinear_integer_upscaler_core u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // beat monitor
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_input(in_tuser, in_tdata[10:0], in_tdata[21:11],
                    {in_tdata[29:22], in_tdata[37:30], in_tdata[45:38]});
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  // receiver with long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 250;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= dst_idle);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT && !done) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_beat(bit mode, int row, int col, logic [23:0] rgb);
    while ($urandom_range(99) < src_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {2'b00, rgb[7:0], rgb[15:8], rgb[23:16], col[10:0], row[10:0]};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (14) @(posedge clk);
  endtask

  task automatic set_scale(logic [3:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.scale_reg = v;
    @(posedge clk);
  endtask

  // one random beat: mostly reads over written windows, else writes and noise
  task automatic random_beat();
    int s, pick, base, r0, c0, r1, c1, lim;
    s = sb.eff_scale();
    lim = 256 * s;
    pick = $urandom_range(99);
    base = $urandom_range(1) ? 240 : 0;
    r0 = base + $urandom_range(15);
    c0 = base + $urandom_range(15);
    r1 = (r0 < 255) ? r0 + 1 : 255;
    c1 = (c0 < 255) ? c0 + 1 : 255;
    if (pick < 55) begin
      if (!sb.is_written(r0, c0)) send_beat(1'b0, r0, c0, $urandom);
      else if (!sb.is_written(r1, c0)) send_beat(1'b0, r1, c0, $urandom);
      else if (!sb.is_written(r0, c1)) send_beat(1'b0, r0, c1, $urandom);
      else if (!sb.is_written(r1, c1)) send_beat(1'b0, r1, c1, $urandom);
      else send_beat(1'b1, r0 * s + $urandom_range(s - 1), c0 * s + $urandom_range(s - 1),
                     $urandom);
    end else if (pick < 85) begin
      send_beat(1'b0, r0, c0, $urandom);
    end else if (pick < 90) begin
      send_beat(1'b0, $urandom_range(2047), $urandom_range(2047), $urandom);
    end else if (lim <= 2047) begin
      if ($urandom_range(1)) send_beat(1'b1, $urandom_range(2047, lim), $urandom_range(2047),
                                       $urandom);
      else send_beat(1'b1, $urandom_range(lim - 1), $urandom_range(2047, lim), $urandom);
    end else begin
      send_beat(1'b1, $urandom_range(2047), $urandom_range(2047), $urandom);
    end
  endtask

  initial begin
    logic [3:0] scales [7];
    int s;
    sb = new();
    scales = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd7, 4'd2};
    cycles = 0;
    done = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 4'd0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    src_idle = 10;
    dst_idle = 72;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners, extremes and ignored writes at the reset scale
    send_beat(1'b0, 0, 0, 24'h000000);
    send_beat(1'b0, 0, 1, 24'hffffff);
    send_beat(1'b0, 1, 0, 24'hff00ff);
    send_beat(1'b0, 1, 1, 24'h00ff00);
    send_beat(1'b0, 0, 2, 24'h80ff01);
    send_beat(1'b0, 1, 2, 24'h7f0033);
    send_beat(1'b0, 2, 1, 24'h55aa00);
    send_beat(1'b0, 2, 2, 24'hfe01c4);
    send_beat(1'b0, 0, 255, 24'hffffff);
    send_beat(1'b0, 1, 255, 24'h00ff80);
    send_beat(1'b0, 254, 254, 24'h123456);
    send_beat(1'b0, 254, 255, 24'hffffff);
    send_beat(1'b0, 255, 254, 24'h000000);
    send_beat(1'b0, 255, 255, 24'hffffff);
    send_beat(1'b0, 256, 5, 24'hffffff);
    send_beat(1'b0, 3, 2047, 24'hffffff);
    send_beat(1'b1, 0, 0, 24'h0);
    send_beat(1'b1, 0, 1, 24'h0);
    send_beat(1'b1, 1, 1, 24'hffffff);
    send_beat(1'b1, 255, 255, 24'h0);
    send_beat(1'b1, 254, 254, 24'h0);
    send_beat(1'b1, 256, 0, 24'h0);
    send_beat(1'b1, 0, 2047, 24'h0);
    send_beat(1'b1, 2047, 2047, 24'h0);

    for (int p = 0; p < 7; p++) begin
      if (p == 3) begin
        src_idle = 72;
        dst_idle = 10;
      end else if (p == 5) begin
        src_idle = 0;
        dst_idle = 0;
      end
      if (p != 0) begin
        drain();
        set_scale(scales[p]);
        s = sb.eff_scale();
        send_beat(1'b1, 0, 0, 24'h0);
        send_beat(1'b1, 256 * s - 1, 256 * s - 1, 24'h0);
        send_beat(1'b1, s - 1, 256 * s - 1, 24'h0);
      end
      if (p == 2 || p == 5) hold_req = 1'b1;
      for (int i = 0; i < 82; i++) random_beat();
    end

    drain();
    done = 1'b1;
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
